@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define DORLT_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define DORLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dorlt_pkg.sv @@
// Package: constants, types and register map of the open-row latency tracker.
`default_nettype none
package dorlt_pkg;

    localparam int BYTE_LANE_BITS = 3;
    localparam int DIMM_BITS       = 1;
    localparam int BANK_BITS       = 3;
    localparam int RANK_BITS       = 1;
    localparam int MAX_ROW_BITS    = 20;
    localparam int ADDR_BITS       = 40;

    localparam int ENTRY_INDEX_BITS = DIMM_BITS + RANK_BITS + BANK_BITS;
    localparam int ENTRY_COUNT      = 1 << ENTRY_INDEX_BITS;

    localparam int FIELD_W = 5;
    localparam int LAT_W   = 16;
    localparam int POS_W   = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 3;
    localparam int PADDR_W  = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_COL_LOW_BITS       = 3'd0,
        REG_COL_HIGH_BITS      = 3'd1,
        REG_ROW_BITS           = 3'd2,
        REG_READ_HIT_LATENCY   = 3'd3,
        REG_WRITE_HIT_LATENCY  = 3'd4,
        REG_READ_MISS_LATENCY  = 3'd5,
        REG_WRITE_MISS_LATENCY = 3'd6
    } reg_idx_t;

    localparam logic [FIELD_W-1:0] COL_LOW_BITS_RST  = 5'd2;
    localparam logic [FIELD_W-1:0] COL_HIGH_BITS_RST = 5'd5;
    localparam logic [FIELD_W-1:0] ROW_BITS_RST      = 5'd14;
    localparam logic [LAT_W-1:0]   HIT_LATENCY_RST   = 16'd25;
    localparam logic [LAT_W-1:0]   MISS_LATENCY_RST  = 16'd65;

    typedef struct packed {
        logic [FIELD_W-1:0] col_low_bits;
        logic [FIELD_W-1:0] col_high_bits;
        logic [FIELD_W-1:0] row_bits;
        logic [LAT_W-1:0]   read_hit_latency;
        logic [LAT_W-1:0]   write_hit_latency;
        logic [LAT_W-1:0]   read_miss_latency;
        logic [LAT_W-1:0]   write_miss_latency;
    } cfg_t;

    typedef struct packed {
        logic                        flush;
        logic                        is_write;
        logic [ENTRY_INDEX_BITS-1:0] idx;
        logic [MAX_ROW_BITS-1:0]     row;
    } req_t;

    typedef struct packed {
        logic pop;
        logic flush;
    } back_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/dorlt_front.sv @@
// Front end: slices the access address into entry index and row.
`default_nettype none
module dorlt_front (
    input  wire logic                             s_kind,
    input  wire logic [dorlt_pkg::ADDR_BITS-1:0]  s_address,
    input  wire logic                             s_is_write,
    input  wire dorlt_pkg::cfg_t                  cfg,
    output dorlt_pkg::req_t                       req
);
    import dorlt_pkg::*;

    logic [POS_W-1:0]        bank_pos;
    logic [POS_W-1:0]        rank_pos;
    logic [POS_W-1:0]        row_pos;
    logic [FIELD_W-1:0]      row_width;
    logic [MAX_ROW_BITS-1:0] row_mask;
    logic [ADDR_BITS-1:0]    bank_sh;
    logic [ADDR_BITS-1:0]    rank_sh;
    logic [ADDR_BITS-1:0]    row_sh;
    logic [DIMM_BITS-1:0]    dimm;
    logic [BANK_BITS-1:0]    bank;
    logic [RANK_BITS-1:0]    rank;

    always_comb begin
        bank_pos = POS_W'(BYTE_LANE_BITS + DIMM_BITS) + POS_W'(cfg.col_low_bits);
        rank_pos = bank_pos + POS_W'(BANK_BITS) + POS_W'(cfg.col_high_bits);
        row_pos  = rank_pos + POS_W'(RANK_BITS);
        row_width = (cfg.row_bits > FIELD_W'(MAX_ROW_BITS)) ?
                    FIELD_W'(MAX_ROW_BITS) : cfg.row_bits;
        row_mask = ~({MAX_ROW_BITS{1'b1}} << row_width);

        bank_sh = s_address >> bank_pos;
        rank_sh = s_address >> rank_pos;
        row_sh  = s_address >> row_pos;

        dimm = s_address[BYTE_LANE_BITS +: DIMM_BITS];
        bank = bank_sh[BANK_BITS-1:0];
        rank = rank_sh[RANK_BITS-1:0];

        req.flush    = s_kind;
        req.is_write = s_is_write;
        req.idx      = {dimm, rank, bank};
        req.row      = row_sh[MAX_ROW_BITS-1:0] & row_mask;
    end

endmodule
`default_nettype wire

@@ hw/rtl/dorlt_fifo.sv @@
// Short request queue between front end and back end.
`default_nettype none
module dorlt_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire dorlt_pkg::req_t   push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output dorlt_pkg::req_t        pop_data
);
    import dorlt_pkg::*;

    req_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    always_comb begin
        push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
        pop_valid  = (count_reg != '0);
        pop_data   = mem_reg[rd_ptr_reg];
        push       = push_valid && push_ready;
        pop        = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/dorlt_back.sv @@
// Back end: open-row table lookup and update, result register.
`default_nettype none
module dorlt_back (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire dorlt_pkg::cfg_t              cfg,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire dorlt_pkg::req_t              req,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [dorlt_pkg::LAT_W-1:0]       m_latency,
    output logic                              m_row_hit,
    output dorlt_pkg::back_stat_t             stat
);
    import dorlt_pkg::*;

    logic [MAX_ROW_BITS-1:0] open_row_reg [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0]  row_valid_reg, row_valid_next;
    logic                    m_valid_reg, m_valid_next;
    logic [LAT_W-1:0]        latency_reg, latency_next;
    logic                    row_hit_reg, row_hit_next;
    logic                    pop;
    logic                    hit;

    always_comb begin
        req_ready = !m_valid_reg || m_ready;
        pop       = req_valid && req_ready;
        hit       = row_valid_reg[req.idx] && (open_row_reg[req.idx] == req.row);

        row_valid_next = row_valid_reg;
        m_valid_next   = m_valid_reg;
        latency_next   = latency_reg;
        row_hit_next   = row_hit_reg;

        if (pop) begin
            m_valid_next = 1'b1;
            if (req.flush) begin
                row_valid_next = '0;
                latency_next   = '0;
                row_hit_next   = 1'b0;
            end else if (hit) begin
                latency_next = req.is_write ? cfg.write_hit_latency : cfg.read_hit_latency;
                row_hit_next = 1'b1;
            end else begin
                row_valid_next[req.idx] = 1'b1;
                latency_next = req.is_write ? cfg.write_miss_latency : cfg.read_miss_latency;
                row_hit_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        stat.pop   = pop;
        stat.flush = req.flush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        latency_reg <= latency_next;
        row_hit_reg <= row_hit_next;
        if (pop && !req.flush && !hit) begin
            open_row_reg[req.idx] <= req.row;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_latency = latency_reg;
    assign m_row_hit = row_hit_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dram_open_row_latency_tracker.sv @@
// Top level: DRAM open-row latency tracker with APB register port.
//
//   channel   dir   handshake              payload
//   s_        in    s_valid / s_ready      s_kind, s_address, s_is_write
//   m_        out   m_valid / m_ready      m_latency, m_row_hit
//   apb       in    psel/penable/pready    paddr, pwdata, prdata
//
// One transaction per cycle sustained while m_ready is held high; an accepted
// transaction is written into the queue, then a table read-modify-write loads the result register.
// Reset clears all open-row valid bits together; no clearing pass.
// Front and back are split by a two-entry queue, so a stalled m_ channel only
// backs up s_ready once the queue and result register are full.
`default_nettype none
module dram_open_row_latency_tracker (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_kind,
    input  wire logic [dorlt_pkg::ADDR_BITS-1:0]    s_address,
    input  wire logic                               s_is_write,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [dorlt_pkg::LAT_W-1:0]             m_latency,
    output logic                                    m_row_hit,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dorlt_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [dorlt_pkg::PDATA_W-1:0]      pwdata,
    output logic [dorlt_pkg::PDATA_W-1:0]           prdata,
    output logic                                    pready
);
    import dorlt_pkg::*;
`include "assert_macros.svh"

    logic [FIELD_W-1:0] col_low_bits_reg, col_low_bits_next;
    logic [FIELD_W-1:0] col_high_bits_reg, col_high_bits_next;
    logic [FIELD_W-1:0] row_bits_reg, row_bits_next;
    logic [LAT_W-1:0]   read_hit_latency_reg, read_hit_latency_next;
    logic [LAT_W-1:0]   write_hit_latency_reg, write_hit_latency_next;
    logic [LAT_W-1:0]   read_miss_latency_reg, read_miss_latency_next;
    logic [LAT_W-1:0]   write_miss_latency_reg, write_miss_latency_next;

    cfg_t               cfg;
    reg_idx_t           reg_idx;
    logic               cfg_wr;
    req_t               fe_req;
    req_t               q_req;
    logic               q_valid;
    logic               q_ready;
    back_stat_t         be_stat;

    always_comb begin
        pready  = 1'b1;
        reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
        cfg_wr  = psel && penable && pwrite && pready;

        col_low_bits_next       = col_low_bits_reg;
        col_high_bits_next      = col_high_bits_reg;
        row_bits_next           = row_bits_reg;
        read_hit_latency_next   = read_hit_latency_reg;
        write_hit_latency_next  = write_hit_latency_reg;
        read_miss_latency_next  = read_miss_latency_reg;
        write_miss_latency_next = write_miss_latency_reg;
        if (cfg_wr) begin
            case (reg_idx)
                REG_COL_LOW_BITS:       col_low_bits_next       = pwdata[FIELD_W-1:0];
                REG_COL_HIGH_BITS:      col_high_bits_next      = pwdata[FIELD_W-1:0];
                REG_ROW_BITS:           row_bits_next           = pwdata[FIELD_W-1:0];
                REG_READ_HIT_LATENCY:   read_hit_latency_next   = pwdata[LAT_W-1:0];
                REG_WRITE_HIT_LATENCY:  write_hit_latency_next  = pwdata[LAT_W-1:0];
                REG_READ_MISS_LATENCY:  read_miss_latency_next  = pwdata[LAT_W-1:0];
                REG_WRITE_MISS_LATENCY: write_miss_latency_next = pwdata[LAT_W-1:0];
                default: ;
            endcase
        end

        case (reg_idx)
            REG_COL_LOW_BITS:       prdata = PDATA_W'(col_low_bits_reg);
            REG_COL_HIGH_BITS:      prdata = PDATA_W'(col_high_bits_reg);
            REG_ROW_BITS:           prdata = PDATA_W'(row_bits_reg);
            REG_READ_HIT_LATENCY:   prdata = PDATA_W'(read_hit_latency_reg);
            REG_WRITE_HIT_LATENCY:  prdata = PDATA_W'(write_hit_latency_reg);
            REG_READ_MISS_LATENCY:  prdata = PDATA_W'(read_miss_latency_reg);
            REG_WRITE_MISS_LATENCY: prdata = PDATA_W'(write_miss_latency_reg);
            default:                prdata = '0;
        endcase

        cfg.col_low_bits       = col_low_bits_reg;
        cfg.col_high_bits      = col_high_bits_reg;
        cfg.row_bits           = row_bits_reg;
        cfg.read_hit_latency   = read_hit_latency_reg;
        cfg.write_hit_latency  = write_hit_latency_reg;
        cfg.read_miss_latency  = read_miss_latency_reg;
        cfg.write_miss_latency = write_miss_latency_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_low_bits_reg       <= COL_LOW_BITS_RST;
            col_high_bits_reg      <= COL_HIGH_BITS_RST;
            row_bits_reg           <= ROW_BITS_RST;
            read_hit_latency_reg   <= HIT_LATENCY_RST;
            write_hit_latency_reg  <= HIT_LATENCY_RST;
            read_miss_latency_reg  <= MISS_LATENCY_RST;
            write_miss_latency_reg <= MISS_LATENCY_RST;
        end else begin
            col_low_bits_reg       <= col_low_bits_next;
            col_high_bits_reg      <= col_high_bits_next;
            row_bits_reg           <= row_bits_next;
            read_hit_latency_reg   <= read_hit_latency_next;
            write_hit_latency_reg  <= write_hit_latency_next;
            read_miss_latency_reg  <= read_miss_latency_next;
            write_miss_latency_reg <= write_miss_latency_next;
        end
    end

    dorlt_front u_front (
        .s_kind     (s_kind),
        .s_address  (s_address),
        .s_is_write (s_is_write),
        .cfg        (cfg),
        .req        (fe_req)
    );

    dorlt_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (fe_req),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_req)
    );

    dorlt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_latency (m_latency),
        .m_row_hit (m_row_hit),
        .stat      (be_stat)
    );

    `DORLT_ASSERT_NEXT(a_flush_result, be_stat.pop && be_stat.flush, m_valid && (m_latency == '0) && !m_row_hit, "flush result not zero")
    `DORLT_ASSERT(a_pop_slot_free, be_stat.pop, !m_valid || m_ready, "result overwritten")
    `DORLT_ASSERT(a_hit_latency, m_valid && m_row_hit, (m_latency == read_hit_latency_reg) || (m_latency == write_hit_latency_reg), "hit with non-hit latency")

endmodule
`default_nettype wire
